@@ rtl/single_float_add_sub_mul_div_unit_defines.svh @@
// assertion macros shared by the checker
`ifndef SINGLE_FLOAT_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH
`define SINGLE_FLOAT_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH

`define SFU_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("sfu check failed");

`define SFU_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("sfu check failed");

`endif

@@ rtl/sfadd_pkg.sv @@
package sfadd_pkg;

   localparam int Bias = 127;
   localparam int MantW = 24;
   localparam int ExpW = 11;
   localparam int DivSteps = 24;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_UNF  = 2'd2,
      ST_DIVZ = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALIGN,
      S_ADD,
      S_NORM,
      S_MUL,
      S_DIV,
      S_PACK,
      S_DONE
   } state_type;

endpackage

@@ rtl/single_float_add_sub_mul_div_unit.sv @@
// Single-precision add, subtract, multiply and divide with a hidden one on every operand and
// zero as the only special value; results truncate. One word at a time, in these steps:
// - add and subtract align the smaller operand one bit at a time, add, then normalize
//   one bit at a time and pack.
// - multiply multiplies, then normalizes and packs.
// - divide runs a radix-2 restoring divide loop, one quotient bit per step, then normalizes and packs.
// - a zero operand goes straight to the result.
// The result waits in its output register, and the next word is taken once it has been delivered.
module single_float_add_sub_mul_div_unit
   import sfadd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_bits,
   output logic [1:0]  rsp_status
);

   state_type state_ff, state_in;
   logic        sa_ff, sa_in, sb_ff, sb_in;
   logic signed [ExpW-1:0] ea_ff, ea_in, eb_ff, eb_in;
   logic [MantW-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [49:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] res_ff, res_in;
   logic [1:0]  st_ff, st_in;

   logic za, zb, start;
   logic signed [ExpW-1:0] ea_w, eb_w;
   logic [MantW:0] rem_sub;

   assign start = req_valid && !req_stall;
   assign za = (req_operand_a[30:0] == 31'd0);
   assign zb = (req_operand_b[30:0] == 31'd0);
   assign ea_w = ExpW'($signed({3'b000, req_operand_a[30:23]})) - ExpW'(Bias);
   assign eb_w = ExpW'($signed({3'b000, req_operand_b[30:23]})) - ExpW'(Bias);
   assign rem_sub = acc_ff[49:25] - {1'b0, mb_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            if (req_action == ACT_ADD || req_action == ACT_SUB) begin
               state_in = (za || zb) ? S_DONE : S_ALIGN;
            end else if (req_action == ACT_MUL) begin
               state_in = (za || zb) ? S_DONE : S_MUL;
            end else begin
               state_in = (za || zb) ? S_DONE : S_DIV;
            end
         end
         S_ALIGN: if (ea_ff == eb_ff || ma_ff == '0) state_in = (ma_ff == '0) ? S_DONE : S_ADD;
         S_ADD:   state_in = S_NORM;
         S_NORM:  if (acc_ff[25:0] == '0) state_in = S_DONE;
                  else if (acc_ff[24:23] == 2'b01) state_in = S_PACK;
         S_MUL:   state_in = S_NORM;
         S_DIV:   if (cnt_ff == 5'd0) state_in = S_NORM;
         S_PACK:  state_in = S_DONE;
         S_DONE:  if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      sa_in = sa_ff; sb_in = sb_ff; ea_in = ea_ff; eb_in = eb_ff;
      ma_in = ma_ff; mb_in = mb_ff; acc_in = acc_ff;
      cnt_in = cnt_ff; res_in = res_ff; st_in = st_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            st_in = ST_OK;
            res_in = 32'd0;
            sa_in = req_operand_a[31];
            sb_in = req_operand_b[31] ^ (req_action == ACT_SUB);
            ma_in = {1'b1, req_operand_a[22:0]};
            mb_in = {1'b1, req_operand_b[22:0]};
            ea_in = ea_w;
            eb_in = eb_w;
            cnt_in = 5'(DivSteps - 1);
            acc_in = {26'd0, 1'b1, req_operand_a[22:0]};
            if (req_action == ACT_ADD || req_action == ACT_SUB) begin
               if (za) res_in = {sb_in, req_operand_b[30:0]};
               else if (zb) res_in = req_operand_a;
               else if (ea_w > eb_w) begin
                  sa_in = sb_in; sb_in = req_operand_a[31];
                  ma_in = {1'b1, req_operand_b[22:0]}; mb_in = {1'b1, req_operand_a[22:0]};
                  ea_in = eb_w; eb_in = ea_w;
               end
            end else if (req_action == ACT_MUL) begin
               sa_in = req_operand_a[31] ^ req_operand_b[31];
               ea_in = ea_w + eb_w;
               if (!za && !zb) begin
                  if (ea_in >= 11'sd128) begin st_in = ST_OVF; end
                  else if (ea_in <= -11'sd127) begin st_in = ST_UNF; end
               end
            end else begin
               sa_in = req_operand_a[31] ^ req_operand_b[31];
               ea_in = ea_w - eb_w;
               if (zb) st_in = ST_DIVZ;
               else if (!za) begin
                  if (ea_in >= 11'sd128) begin st_in = ST_OVF; end
                  else if (ea_in <= -11'sd127) begin st_in = ST_UNF; end
               end
               // remainder in acc[49:25], quotient bits in acc[23:0]
               acc_in = {1'b0, 1'b1, req_operand_a[22:0], 25'd0};
            end
         end
         S_ALIGN: begin
            if (ma_ff == '0) res_in = {sb_ff, eb_ff[7:0] + 8'd127, mb_ff[22:0]};
            else if (ea_ff != eb_ff) begin
               ma_in = ma_ff >> 1;
               ea_in = ea_ff + 11'sd1;
            end
         end
         S_ADD: begin
            acc_in = 50'($signed({2'b00, sa_ff ? -{2'b00, ma_ff} : {2'b00, ma_ff}})
                   + $signed({2'b00, sb_ff ? -{2'b00, mb_ff} : {2'b00, mb_ff}}));
            if (acc_in[25]) begin
               sa_in = 1'b1;
               acc_in = {24'd0, -acc_in[25:0]};
            end else begin
               sa_in = 1'b0;
               acc_in = {24'd0, acc_in[25:0]};
            end
            ea_in = eb_ff;
         end
         S_NORM: begin
            if (acc_ff[25:24] != 2'b00) begin
               acc_in = acc_ff >> 1;
               ea_in = ea_ff + 11'sd1;
            end else if (!acc_ff[23]) begin
               acc_in = {acc_ff[48:0], 1'b0};
               ea_in = ea_ff - 11'sd1;
            end
         end
         S_MUL: begin
            acc_in = 50'(({24'd0, ma_ff} * {24'd0, mb_ff}) >> 23);
            if (st_ff != ST_OK) res_in = 32'd0;
         end
         S_DIV: begin
            if (!rem_sub[MantW]) acc_in = {rem_sub[23:0], 2'b00, acc_ff[23:0]};
            else acc_in = {acc_ff[48:25], 2'b00, acc_ff[23:0]};
            acc_in[23:0] = {acc_ff[22:0], !rem_sub[MantW]};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) acc_in[49:24] = 26'd0;
         end
         S_PACK: begin
            if (st_ff == ST_OK) begin
               if (ea_ff >= 11'sd128) st_in = ST_OVF;
               else if (ea_ff <= -11'sd127) st_in = ST_UNF;
               else res_in = {sa_ff, ea_ff[7:0] + 8'd127, acc_ff[22:0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      sa_ff <= sa_in; sb_ff <= sb_in; ea_ff <= ea_in; eb_ff <= eb_in;
      ma_ff <= ma_in; mb_ff <= mb_in; acc_ff <= acc_in;
      cnt_ff <= cnt_in; res_ff <= res_in; st_ff <= st_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_result_bits = (st_ff == ST_OK) ? res_ff : 32'd0;
   assign rsp_status = st_ff;

endmodule

@@ rtl/sfadd_checker.sv @@
`include "single_float_add_sub_mul_div_unit_defines.svh"
module sfadd_checker
   import sfadd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_bits,
   input logic [1:0]  rsp_status
);
   `SFU_ASSERT_IMP(err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_result_bits == 32'd0)
   `SFU_ASSERT_NEXT(busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   `SFU_ASSERT_IMP(no_take_while_out, clock, reset, rsp_valid, req_stall)
   `SFU_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_bits))
endmodule

bind single_float_add_sub_mul_div_unit sfadd_checker u_sfadd_checker (.*);

@@ verif/tb_single_float_add_sub_mul_div_unit.sv @@
`timescale 1ns / 100ps

module tb_single_float_add_sub_mul_div_unit;
   import sfadd_pkg::*;

   typedef struct packed {
      action_type  act;
      logic [31:0] a;
      logic [31:0] b;
   } op_word_type;

   typedef struct packed {
      logic [31:0] bits;
      status_type  st;
   } fp_result_type;

   localparam int IdleLimit = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_bits;
   logic [1:0]  rsp_status;

   op_word_type   pending_ops[$];
   fp_result_type expected_results[$];
   int         error_count = 0;
   int         idle_cycles = 0;
   int         send_gap = 0;
   int         recv_gap = 0;
   bit         stim_done = 1'b0;
   bit         drain_hold = 1'b0;

   single_float_add_sub_mul_div_unit u_top (.*);

   always #5 clock = ~clock;

   function automatic fp_result_type fp_pack(logic s, int e, longint unsigned m);
      fp_result_type r;
      r.bits = '0;
      r.st = ST_OK;
      if (e >= 128) r.st = ST_OVF;
      else if (e <= -127) r.st = ST_UNF;
      else r.bits = {s, 8'(e + 127), m[22:0]};
      return r;
   endfunction

   function automatic fp_result_type fp_compute(op_word_type w);
      fp_result_type r;
      logic [31:0] a, b, t;
      int ea, eb, sh, e;
      longint sum;
      longint unsigned ma, mb, m;
      logic s;
      r.bits = '0;
      r.st = ST_OK;
      a = w.a;
      b = w.b;
      if (w.act == ACT_SUB) b[31] = ~b[31];
      ea = int'(a[30:23]) - 127;
      eb = int'(b[30:23]) - 127;
      ma = {1'b1, a[22:0]};
      mb = {1'b1, b[22:0]};
      s = a[31] ^ b[31];
      case (w.act)
         ACT_ADD, ACT_SUB: begin
            if (a[30:0] == 0) begin
               r.bits = b;
               return r;
            end
            if (b[30:0] == 0) begin
               r.bits = a;
               return r;
            end
            if (ea > eb) begin
               t = a; a = b; b = t;
            end
            ea = int'(a[30:23]) - 127;
            eb = int'(b[30:23]) - 127;
            ma = {1'b1, a[22:0]};
            mb = {1'b1, b[22:0]};
            sh = eb - ea;
            ma = (sh >= 24) ? 0 : (ma >> sh);
            if (ma == 0) begin
               r.bits = b;
               return r;
            end
            sum = (a[31] ? -longint'(ma) : longint'(ma)) + (b[31] ? -longint'(mb) : longint'(mb));
            if (sum == 0) return r;
            s = 1'b0;
            if (sum < 0) begin
               s = 1'b1;
               sum = -sum;
            end
            m = sum;
            while (m >= 64'h100_0000) begin
               m >>= 1;
               eb++;
            end
            while (m[23] == 1'b0) begin
               m <<= 1;
               eb--;
            end
            return fp_pack(s, eb, m);
         end
         ACT_MUL: begin
            if (a[30:0] == 0 || b[30:0] == 0) return r;
            e = ea + eb;
            if (e >= 128 || e <= -127) return fp_pack(s, e, 0);
            m = (ma * mb) >> 23;
            if (m >= 64'h100_0000) begin
               m >>= 1;
               e++;
            end
            return fp_pack(s, e, m);
         end
         default: begin
            if (b[30:0] == 0) begin
               r.st = ST_DIVZ;
               return r;
            end
            if (a[30:0] == 0) return r;
            e = ea - eb;
            if (e >= 128 || e <= -127) return fp_pack(s, e, 0);
            m = (ma << 23) / mb;
            if (m[23] == 1'b0) begin
               m <<= 1;
               e--;
            end
            return fp_pack(s, e, m);
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] rand_operand();
      logic [31:0] v;
      int p;
      v = $urandom;
      p = $urandom_range(0, 9);
      if (p == 0) v[30:0] = '0;
      else if (p < 5) v[30:23] = 8'($urandom_range(100, 154));
      return v;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (send_gap > 0 || drain_hold || pending_ops.size() == 0) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else begin
            op_word_type w;
            w = pending_ops.pop_front();
            expected_results.push_back(fp_compute(w));
            req_valid <= 1'b1;
            req_action <= w.act;
            req_operand_a <= w.a;
            req_operand_b <= w.b;
            send_gap <= pick_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("word with nothing expected: %h %0d", rsp_result_bits, rsp_status);
               error_count++;
            end else begin
               fp_result_type x;
               x = expected_results.pop_front();
               if (rsp_result_bits !== x.bits) begin
                  $error("result_bits expected %h actual %h", x.bits, rsp_result_bits);
                  error_count++;
               end
               if (rsp_status !== x.st) begin
                  $error("status expected %0d actual %0d", x.st, rsp_status);
                  error_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            recv_gap <= pick_gap();
            rsp_stall <= 1'b0;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("tb_single_float_add_sub_mul_div_unit failed");
            $finish;
         end
      end
   end

   initial begin
      op_word_type w;
      logic [31:0] dir_ops[10];
      dir_ops = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBFC0_0000,
                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                  32'h4B80_0000, 32'h3F7F_FFFF};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 24; i++) begin
         w.act = action_type'(i % 4);
         w.a = dir_ops[i % 10];
         w.b = dir_ops[(i * 3 + i / 4) % 10];
         pending_ops.push_back(w);
      end
      for (int i = 0; i < 900; i++) begin
         w.act = action_type'($urandom_range(0, 3));
         w.a = rand_operand();
         w.b = ($urandom_range(0, 3) == 0) ? w.a ^ (32'($urandom_range(0, 1)) << 31)
                                          : rand_operand();
         pending_ops.push_back(w);
         if (i == 450) begin
            wait (pending_ops.size() == 0);
            drain_hold = 1'b1;
            wait (expected_results.size() == 0);
            drain_hold = 1'b0;
         end
      end
      wait (pending_ops.size() == 0 && expected_results.size() == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("tb_single_float_add_sub_mul_div_unit passed");
      else
         $display("tb_single_float_add_sub_mul_div_unit failed");
      $finish;
   end

endmodule
